/* hdl/palette_shade_remap_core_assert.svh */
// ----------------------------------------------------------------------------
// Palette shade remap core assertion macros
// Concurrent property checks clocked on clk, held off during rst.
// ----------------------------------------------------------------------------
`ifndef PALETTE_SHADE_REMAP_CORE_ASSERT_SVH
`define PALETTE_SHADE_REMAP_CORE_ASSERT_SVH

// same-cycle implication
`define PSR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/palsr_pkg.sv */
// ----------------------------------------------------------------------------
// palsr_pkg
// Shared types, widths and constants of the palette shade remap core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package palsr_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

  localparam int IDX_W  = 8;
  localparam int CH_W   = 8;
  localparam int TINT_W = 10;
  localparam int DIST_W = 10;
  localparam int IN_W   = 64;
  localparam int OUT_W  = 40;

  localparam int LUM_R = 299;
  localparam int LUM_G = 587;
  localparam int LUM_B = 114;

  localparam int LUMP_W    = 18;
  localparam int LUM_SHIFT = 28;
  localparam int REC1K_W   = 19;
  localparam logic [REC1K_W-1:0] RECIP_1000 =
    REC1K_W'(((64'd1 << LUM_SHIFT) + 64'd999) / 64'd1000);

  localparam int SHP_W     = TINT_W + CH_W;
  localparam int SHD_W     = 16;
  localparam int SHD_SHIFT = 24;
  localparam int REC255_W  = 17;
  localparam logic [REC255_W-1:0] RECIP_255 =
    REC255_W'(((64'd1 << SHD_SHIFT) + 64'd254) / 64'd255);

  localparam int CH_MAX = 255;
  localparam logic [SHP_W-1:0] CLAMP_LIMIT = SHP_W'(CH_MAX * 256);
  localparam logic [DIST_W-1:0] DIST_START = '1;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_REMAP = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LUM_MUL,
    ST_LUM_DIV,
    ST_LUM_SUM,
    ST_SHADE_MUL,
    ST_SHADE_DIV,
    ST_SEARCH,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic pad;
    logic mono;
    logic [TINT_W-1:0] tint_blue;
    logic [TINT_W-1:0] tint_green;
    logic [TINT_W-1:0] tint_red;
    logic [CH_W-1:0] load_blue;
    logic [CH_W-1:0] load_green;
    logic [CH_W-1:0] load_red;
    logic [IDX_W-1:0] entry_index;
  } in_data_t;

  typedef struct packed {
    logic [IDX_W-1:0] nearest_index;
    logic [CH_W-1:0] shaded_blue;
    logic [CH_W-1:0] shaded_green;
    logic [CH_W-1:0] shaded_red;
    logic [IDX_W-1:0] result_index;
  } out_data_t;

  typedef struct packed {
    logic load_wr;
    logic capture;
    logic fetch;
    logic lum_mul;
    logic lum_div;
    logic lum_sum;
    logic shade_mul;
    logic shade_div;
    logic scan;
  } dp_cmd_t;

  typedef struct packed {
    logic req_zero;
    logic scan_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* hdl/palsr_ctrl.sv */
// ----------------------------------------------------------------------------
// palsr_ctrl
// Sequencer for loads, shading steps, palette scan and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module palsr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire palsr_pkg::kind_t     in_kind,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire palsr_pkg::dp_status_t status,
  output palsr_pkg::dp_cmd_t        cmd
);

  palsr_pkg::state_t state;
  palsr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= palsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      palsr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == palsr_pkg::KIND_REMAP) begin
            cmd.capture = 1'b1;
            state_next  = palsr_pkg::ST_READ;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      palsr_pkg::ST_READ: begin
        cmd.fetch  = 1'b1;
        state_next = palsr_pkg::ST_LUM_MUL;
      end
      palsr_pkg::ST_LUM_MUL: begin
        cmd.lum_mul = 1'b1;
        state_next  = palsr_pkg::ST_LUM_DIV;
      end
      palsr_pkg::ST_LUM_DIV: begin
        cmd.lum_div = 1'b1;
        state_next  = palsr_pkg::ST_LUM_SUM;
      end
      palsr_pkg::ST_LUM_SUM: begin
        cmd.lum_sum = 1'b1;
        state_next  = palsr_pkg::ST_SHADE_MUL;
      end
      palsr_pkg::ST_SHADE_MUL: begin
        cmd.shade_mul = 1'b1;
        state_next    = palsr_pkg::ST_SHADE_DIV;
      end
      palsr_pkg::ST_SHADE_DIV: begin
        cmd.shade_div = 1'b1;
        // entry zero skips the scan
        state_next = status.req_zero ? palsr_pkg::ST_DONE : palsr_pkg::ST_SEARCH;
      end
      palsr_pkg::ST_SEARCH: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = palsr_pkg::ST_DRAIN;
        end
      end
      palsr_pkg::ST_DRAIN: begin
        state_next = palsr_pkg::ST_DONE;
      end
      palsr_pkg::ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = palsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = palsr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/palsr_dp.sv */
// ----------------------------------------------------------------------------
// palsr_dp
// Palette memory, luminance and tint arithmetic, nearest-entry comparator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module palsr_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire palsr_pkg::dp_cmd_t    cmd,
  input  wire palsr_pkg::in_data_t   in_data,
  output palsr_pkg::dp_status_t      status,
  output palsr_pkg::out_data_t       out_data
);

  localparam int AW  = palsr_pkg::PAL_AW;
  localparam int CW  = palsr_pkg::CH_W;
  localparam int TW  = palsr_pkg::TINT_W;
  localparam int PW  = palsr_pkg::LUMP_W;
  localparam int SW  = palsr_pkg::SHP_W;
  localparam int DW  = palsr_pkg::DIST_W;
  localparam int LQW = palsr_pkg::LUMP_W + palsr_pkg::REC1K_W;
  localparam int SQW = palsr_pkg::SHD_W + palsr_pkg::REC255_W;
  localparam int LS  = palsr_pkg::LUM_SHIFT;
  localparam int SS  = palsr_pkg::SHD_SHIFT;

  logic [3*CW-1:0] mem [palsr_pkg::PALETTE_ENTRIES];
  logic [3*CW-1:0] rd_data;
  logic [AW-1:0]   rd_addr;
  logic            in_range;

  logic [palsr_pkg::IDX_W-1:0] req_idx;
  logic          req_black;
  logic [TW-1:0] tint_r, tint_g, tint_b;
  logic          mono;

  logic [CW-1:0] base_r, base_g, base_b;
  logic [PW-1:0] lum_pr, lum_pg, lum_pb;
  logic [CW-1:0] lum_qr, lum_qg, lum_qb;
  logic [CW-1:0] lum;
  logic [SW-1:0] shp_r, shp_g, shp_b;
  logic [CW-1:0] shd_r, shd_g, shd_b;

  logic [AW-1:0] scan_addr;
  logic          cmp_valid;
  logic [AW-1:0] cmp_idx;
  logic [DW-1:0] best_dist;
  logic [AW-1:0] best_idx;

  logic [CW-1:0]  col_r, col_g, col_b;
  logic [LQW-1:0] lq_r, lq_g, lq_b;
  logic [CW+1:0]  lum_sum;
  logic [CW-1:0]  sel_r, sel_g, sel_b;
  logic [SQW-1:0] sq_r, sq_g, sq_b;
  logic [CW-1:0]  dr, dg, db;
  logic [DW-1:0]  delta;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CW-1:0] shade_q(input logic [SW-1:0] p, input logic [SQW-1:0] q);
    shade_q = (p >= palsr_pkg::CLAMP_LIMIT) ? CW'(palsr_pkg::CH_MAX) : q[SS+CW-1:SS];
  endfunction

  assign in_range = {1'b0, in_data.entry_index} <
                    (palsr_pkg::IDX_W + 1)'(palsr_pkg::PALETTE_ENTRIES);
  assign rd_addr  = cmd.scan ? scan_addr : req_idx[AW-1:0];

  // palette memory
  always_ff @(posedge clk) begin
    if (cmd.load_wr && in_range) begin
      mem[in_data.entry_index[AW-1:0]] <= {in_data.load_red, in_data.load_green,
                                           in_data.load_blue};
    end
    if (cmd.fetch || cmd.scan) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    col_r   = req_black ? '0 : rd_data[3*CW-1:2*CW];
    col_g   = req_black ? '0 : rd_data[2*CW-1:CW];
    col_b   = req_black ? '0 : rd_data[CW-1:0];
    lq_r    = LQW'(lum_pr) * LQW'(palsr_pkg::RECIP_1000);
    lq_g    = LQW'(lum_pg) * LQW'(palsr_pkg::RECIP_1000);
    lq_b    = LQW'(lum_pb) * LQW'(palsr_pkg::RECIP_1000);
    lum_sum = (CW + 2)'(lum_qr) + (CW + 2)'(lum_qg) + (CW + 2)'(lum_qb);
    sel_r   = mono ? lum : base_r;
    sel_g   = mono ? lum : base_g;
    sel_b   = mono ? lum : base_b;
    sq_r    = SQW'(shp_r[palsr_pkg::SHD_W-1:0]) * SQW'(palsr_pkg::RECIP_255);
    sq_g    = SQW'(shp_g[palsr_pkg::SHD_W-1:0]) * SQW'(palsr_pkg::RECIP_255);
    sq_b    = SQW'(shp_b[palsr_pkg::SHD_W-1:0]) * SQW'(palsr_pkg::RECIP_255);
    dr      = abs_diff(rd_data[3*CW-1:2*CW], shd_r);
    dg      = abs_diff(rd_data[2*CW-1:CW], shd_g);
    db      = abs_diff(rd_data[CW-1:0], shd_b);
    delta   = DW'(dr) + DW'(dg) + DW'(db);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_idx   <= in_data.entry_index;
      req_black <= !in_range;
      tint_r    <= in_data.tint_red;
      tint_g    <= in_data.tint_green;
      tint_b    <= in_data.tint_blue;
      mono      <= in_data.mono;
    end
    if (cmd.lum_mul) begin
      base_r <= col_r;
      base_g <= col_g;
      base_b <= col_b;
      lum_pr <= PW'(col_r) * PW'(palsr_pkg::LUM_R);
      lum_pg <= PW'(col_g) * PW'(palsr_pkg::LUM_G);
      lum_pb <= PW'(col_b) * PW'(palsr_pkg::LUM_B);
    end
    if (cmd.lum_div) begin
      lum_qr <= lq_r[LS+CW-1:LS];
      lum_qg <= lq_g[LS+CW-1:LS];
      lum_qb <= lq_b[LS+CW-1:LS];
    end
    if (cmd.lum_sum) begin
      lum <= lum_sum[CW-1:0];
    end
    if (cmd.shade_mul) begin
      shp_r <= SW'(tint_r) * SW'(sel_r);
      shp_g <= SW'(tint_g) * SW'(sel_g);
      shp_b <= SW'(tint_b) * SW'(sel_b);
    end
    if (cmd.shade_div) begin
      shd_r <= shade_q(shp_r, sq_r);
      shd_g <= shade_q(shp_g, sq_g);
      shd_b <= shade_q(shp_b, sq_b);
    end
  end

  // palette scan, entries 1 up to the last
  always_ff @(posedge clk) begin
    if (cmd.shade_div) begin
      scan_addr <= AW'(1);
      best_dist <= palsr_pkg::DIST_START;
      best_idx  <= '0;
    end else begin
      if (cmd.scan) begin
        scan_addr <= scan_addr + AW'(1);
      end
      if (cmp_valid && (delta < best_dist)) begin
        best_dist <= delta;
        best_idx  <= cmp_idx;
      end
    end
    cmp_idx <= scan_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan;
    end
  end

  assign status.req_zero  = (req_idx == '0);
  assign status.scan_last = (scan_addr == AW'(palsr_pkg::PALETTE_ENTRIES - 1));

  assign out_data.result_index  = req_idx;
  assign out_data.shaded_red    = shd_r;
  assign out_data.shaded_green  = shd_g;
  assign out_data.shaded_blue   = shd_b;
  assign out_data.nearest_index = palsr_pkg::IDX_W'(best_idx);

endmodule

`default_nettype wire

/* hdl/palette_shade_remap_core.sv */
// ----------------------------------------------------------------------------
// palette_shade_remap_core
// Palette store with tinted shade and nearest-entry remap.
// ----------------------------------------------------------------------------
//  channel  | ports                       | moves
//  ---------+-----------------------------+--------------------------------
//  input    | s_tvalid s_tready s_tdata   | palette load or remap request
//           | s_tuser                     | kind
//  output   | m_tvalid m_tready m_tdata   | shaded colour and nearest entry
//
// A load is written straight from the idle state. A remap runs six shading steps,
// then, except for entry zero, scans the palette through the single read port
// one entry per cycle before the result is offered.
// Reset clears the sequencer and the compare-valid flag only; palette contents are undefined until loaded.
// s_tready is low from a remap item until its result is taken; m_tvalid holds
// the result through any output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module palette_shade_remap_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // entry_index, load_red, load_green, load_blue, tint_red, tint_green,
  // tint_blue, mono, zero pad
  input  wire logic [palsr_pkg::IN_W-1:0]  s_tdata,
  // kind
  input  wire logic                        s_tuser,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // result_index, shaded_red, shaded_green, shaded_blue, nearest_index
  output logic [palsr_pkg::OUT_W-1:0]      m_tdata
);

  palsr_pkg::dp_cmd_t    cmd;
  palsr_pkg::dp_status_t status;
  palsr_pkg::in_data_t   in_data;
  palsr_pkg::out_data_t  out_data;
  palsr_pkg::kind_t      in_kind;

  assign in_data = palsr_pkg::in_data_t'(s_tdata);
  assign in_kind = palsr_pkg::kind_t'(s_tuser);
  assign m_tdata = palsr_pkg::OUT_W'(out_data);

  palsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_kind   (in_kind),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  palsr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

`include "palette_shade_remap_core_assert.svh"

`PSR_ASSERT_SAME(a_no_accept_with_result, m_tvalid, !s_tready, "input taken while result pending")
`PSR_ASSERT_SAME(a_scan_blocks_input, cmd.scan, !s_tready && !m_tvalid, "scan overlaps handshake")
`PSR_ASSERT_NEXT(a_no_early_result, s_tvalid && s_tready && s_tuser, !m_tvalid, "early result")
`PSR_ASSERT_SAME(a_cmd_item, cmd.load_wr || cmd.capture, s_tvalid && s_tready, "stray command")

endmodule

`default_nettype wire
